@@ hdl/sync_length_frame_deframer_top_defines.svh @@
// Assertion macros for the sync/length frame deframer.
// Included by the top level; needs nothing else.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is low.
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ hdl/slfd_pkg.sv @@
// Types and constants of the sync/length frame deframer.
// Stand-alone; imported by the top level.
package slfd_pkg;

    // Largest sync word the block may be built for, and the bound actually applied.
    localparam int MAX_SYNC_BYTES = 4;
    localparam int SYNC_LIMIT     = (MAX_SYNC_BYTES < 4) ? MAX_SYNC_BYTES : 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [1:0] CFG_SYNC_COUNT   = 2'd1;
    localparam logic [1:0] CFG_LENGTH_BE    = 2'd2;

    localparam int BYTES_LEFT_W = 17;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_first;
        logic       frame_last;
    } t_result;

endpackage

@@ hdl/sync_length_frame_deframer_top.sv @@
// Frame bytes are registered in r_out, or in r_skid while m_axis is held.
// One byte per cycle while the skid is empty; phase/count registers update in one pass.
// A two-entry output stage (register plus skid) keeps input flowing while a result waits.
// Reset (synchronous, active low) returns to hunting with sync_count 2, big-endian length
// and a zero sync pattern, and drops any pending result.
`include "sync_length_frame_deframer_top_defines.svh"

module sync_length_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // frame bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic [0:0]  m_axis_tuser,   // [0] frame_first
    output logic        m_axis_tlast    // frame_last
);
    import slfd_pkg::*;

    logic [31:0]             r_sync_pattern;
    logic [2:0]              r_sync_count;
    logic                    r_length_be;

    t_phase                  r_phase, n_phase;
    logic [1:0]              r_sync_index, n_sync_index;
    logic [7:0]              r_first_len, n_first_len;
    logic [BYTES_LEFT_W-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]              r_header_index, n_header_index;

    logic                    r_out_valid, r_skid_valid;
    t_result                 r_out, r_skid;

    logic                    in_acc, out_acc, res_valid;
    t_result                 res;

    logic [2:0]              eff_count;
    logic [1:0]              hunt_index;
    logic [1:0]              byte_sel;
    logic [7:0]              expect_byte;
    logic [15:0]             length;
    logic [BYTES_LEFT_W-1:0] left_dec;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_out_valid && m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.frame_byte;
    assign m_axis_tuser  = r_out.frame_first;
    assign m_axis_tlast  = r_out.frame_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= '0;
            r_sync_count   <= 3'd2;
            r_length_be    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SYNC_PATTERN: r_sync_pattern <= i_cfg_data;
                CFG_SYNC_COUNT:   r_sync_count   <= i_cfg_data[2:0];
                CFG_LENGTH_BE:    r_length_be    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the sync count to 1..SYNC_LIMIT
    always_comb begin
        if (r_sync_count == 3'd0) begin
            eff_count = 3'd1;
        end else if (r_sync_count > 3'(SYNC_LIMIT)) begin
            eff_count = 3'(SYNC_LIMIT);
        end else begin
            eff_count = r_sync_count;
        end
    end

    // restart the hunt if the count dropped to or below the current index
    assign hunt_index = ({1'b0, r_sync_index} >= eff_count) ? 2'd0 : r_sync_index;
    assign byte_sel   = 2'(eff_count - 3'd1 - {1'b0, hunt_index});

    always_comb begin
        unique case (byte_sel)
            2'd0: expect_byte = r_sync_pattern[7:0];
            2'd1: expect_byte = r_sync_pattern[15:8];
            2'd2: expect_byte = r_sync_pattern[23:16];
            2'd3: expect_byte = r_sync_pattern[31:24];
            default: expect_byte = r_sync_pattern[7:0];
        endcase
    end

    assign length   = r_length_be ? {r_first_len, s_axis_tdata} : {s_axis_tdata, r_first_len};
    assign left_dec = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

    always_comb begin
        n_phase          = r_phase;
        n_sync_index     = r_sync_index;
        n_header_index   = r_header_index;
        n_first_len      = r_first_len;
        n_bytes_left     = r_bytes_left;
        res_valid        = 1'b0;
        res.frame_byte   = s_axis_tdata;
        res.frame_first  = 1'b0;
        res.frame_last   = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                res_valid = 1'b1;
                if (r_header_index == 2'd0) begin
                    res.frame_first = 1'b1;
                    n_header_index  = 2'd1;
                end else if (r_header_index == 2'd1) begin
                    n_first_len    = s_axis_tdata;
                    n_header_index = 2'd2;
                end else begin
                    n_bytes_left   = {1'b0, length} + BYTES_LEFT_W'(3);
                    n_header_index = 2'd0;
                    n_phase        = PH_DATA;
                end
            end
            PH_DATA: begin
                res_valid    = 1'b1;
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    res.frame_last = 1'b1;
                    n_phase        = PH_HUNT;
                    n_sync_index   = 2'd0;
                end
            end
            default: begin
                // hunting, and the unused phase code
                n_phase = PH_HUNT;
                if (s_axis_tdata != expect_byte) begin
                    n_sync_index = 2'd0;
                end else if ({1'b0, hunt_index} + 3'd1 >= eff_count) begin
                    n_sync_index   = 2'd0;
                    n_header_index = 2'd0;
                    n_phase        = PH_HEADER;
                end else begin
                    n_sync_index = hunt_index + 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_sync_index   <= '0;
            r_header_index <= '0;
            r_first_len    <= '0;
            r_bytes_left   <= '0;
        end else if (in_acc) begin
            r_phase        <= n_phase;
            r_sync_index   <= n_sync_index;
            r_header_index <= n_header_index;
            r_first_len    <= n_first_len;
            r_bytes_left   <= n_bytes_left;
        end
    end

    // output register with skid: park a new result when the output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_acc) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc && res_valid;
                end
            end else if (in_acc && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_acc) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (r_out_valid && !out_acc && in_acc && res_valid) begin
            r_skid <= res;
        end
    end

    `SLFD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SLFD_ASSERT_NOW(a_first_not_last, i_clk, i_rst_n, r_out_valid,
        !(r_out.frame_first && r_out.frame_last))
    `SLFD_ASSERT_NEXT(a_header_gives_result, i_clk, i_rst_n,
        in_acc && r_phase == PH_HEADER, r_out_valid)
    `SLFD_ASSERT_NEXT(a_last_back_to_hunt, i_clk, i_rst_n,
        in_acc && r_phase == PH_DATA && r_bytes_left <= BYTES_LEFT_W'(1),
        r_phase == PH_HUNT && r_sync_index == 2'd0)

endmodule
